// ----- sv/aatb_pkg.sv -----
package aatb_pkg;

  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = 12;
  localparam int COEF_ONE  = 4096;
  localparam int ROW_W     = 48;
  localparam int SHIFT_W   = 32;
  localparam int NUM_AXES  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Z = 3'd5;

  // Transform settings: one coefficient row and one translation per output axis.
  typedef struct packed {
    logic [NUM_AXES-1:0][ROW_W-1:0]   row;
    logic [NUM_AXES-1:0][SHIFT_W-1:0] shift;
  } cfg_t;

endpackage

// ----- sv/aabb_affine_transform_bound.sv -----
// Transformed box bound: one box per cycle while the output is not stalled, one bound per box.
// The result passes through the front register, the queue, the multiply
// stage, the sum stage and the translate and saturate stage.
// Throughput: one transfer per cycle without back-pressure; the two-entry
// queue and per-stage handshakes let input and output stall independently.
// Reset clears all valid state and loads the identity transform.
module aabb_affine_transform_bound import aatb_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]                   cfg_data_i,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z, zero pad
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // bound_lo_x, bound_lo_y, bound_lo_z, bound_hi_x, bound_hi_y, bound_hi_z, zero pad
  output logic [((6*COORD_WIDTH+7)/8)*8-1:0]      m_axis_tdata
);

  localparam int CW     = COORD_WIDTH;
  localparam int BOX_W  = 2 * NUM_AXES * CW;

  cfg_t cfg_q;

  logic [NUM_AXES-1:0][CW-1:0] in_lo, in_hi;
  logic                        fr_valid, fr_ready;
  logic [NUM_AXES-1:0][CW-1:0] fr_lo, fr_hi;
  logic                        q_valid, q_ready;
  logic [BOX_W-1:0]            q_data;
  logic [NUM_AXES-1:0][CW-1:0] q_lo, q_hi;
  logic [NUM_AXES-1:0][CW-1:0] bd_lo, bd_hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row[0]   <= ROW_W'(COEF_ONE);
      cfg_q.row[1]   <= ROW_W'(COEF_ONE) << COEF_W;
      cfg_q.row[2]   <= ROW_W'(COEF_ONE) << (2 * COEF_W);
      cfg_q.shift[0] <= '0;
      cfg_q.shift[1] <= '0;
      cfg_q.shift[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW_X:   cfg_q.row[0]   <= cfg_data_i[ROW_W-1:0];
        CFG_ROW_Y:   cfg_q.row[1]   <= cfg_data_i[ROW_W-1:0];
        CFG_ROW_Z:   cfg_q.row[2]   <= cfg_data_i[ROW_W-1:0];
        CFG_SHIFT_X: cfg_q.shift[0] <= cfg_data_i[SHIFT_W-1:0];
        CFG_SHIFT_Y: cfg_q.shift[1] <= cfg_data_i[SHIFT_W-1:0];
        CFG_SHIFT_Z: cfg_q.shift[2] <= cfg_data_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      in_lo[k] = s_axis_tdata[k*CW +: CW];
      in_hi[k] = s_axis_tdata[(NUM_AXES+k)*CW +: CW];
    end
  end

  aatb_front #(
    .CW (CW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_lo_i     (in_lo),
    .in_hi_i     (in_hi),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_lo_o    (fr_lo),
    .out_hi_o    (fr_hi)
  );

  aatb_fifo #(
    .WIDTH (BOX_W),
    .DEPTH (2)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_data_i   ({fr_hi, fr_lo}),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_data)
  );

  assign q_lo = q_data[NUM_AXES*CW-1:0];
  assign q_hi = q_data[BOX_W-1:NUM_AXES*CW];

  aatb_back #(
    .CW (CW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_lo_i     (q_lo),
    .in_hi_i     (q_hi),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_lo_o    (bd_lo),
    .out_hi_o    (bd_hi)
  );

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[BOX_W-1:0] = {bd_hi, bd_lo};
  end

endmodule

// ----- sv/aatb_front.sv -----
module aatb_front import aatb_pkg::*; #(
  parameter int CW = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [NUM_AXES-1:0][CW-1:0]   in_lo_i,
  input  logic [NUM_AXES-1:0][CW-1:0]   in_hi_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [NUM_AXES-1:0][CW-1:0]   out_lo_o,
  output logic [NUM_AXES-1:0][CW-1:0]   out_hi_o
);

  logic                        valid_q;
  logic [NUM_AXES-1:0][CW-1:0] lo_q, lo_d;
  logic [NUM_AXES-1:0][CW-1:0] hi_q, hi_d;
  logic                        load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // Order each coordinate pair so the back end can pick a corner from the
  // coefficient sign alone.
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      if ($signed(in_hi_i[k]) < $signed(in_lo_i[k])) begin
        lo_d[k] = in_hi_i[k];
        hi_d[k] = in_lo_i[k];
      end else begin
        lo_d[k] = in_lo_i[k];
        hi_d[k] = in_hi_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_lo_o    = lo_q;
  assign out_hi_o    = hi_q;

`ifndef SYNTHESIS
  a_front_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ($signed(lo_q[0]) <= $signed(hi_q[0])) &&
                ($signed(lo_q[1]) <= $signed(hi_q[1])) &&
                ($signed(lo_q[2]) <= $signed(hi_q[2])))
    else $error("front corner pair is not ordered");
`endif

endmodule

// ----- sv/aatb_fifo.sv -----
module aatb_fifo #(
  parameter int WIDTH = 192,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign in_ready_o  = count_q != CNT_W'(DEPTH);
  assign out_valid_o = count_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

`ifndef SYNTHESIS
  a_fifo_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill count did not follow a lone write");
`endif

endmodule

// ----- sv/aatb_back.sv -----
module aatb_back import aatb_pkg::*; #(
  parameter int CW = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [NUM_AXES-1:0][CW-1:0]   in_lo_i,
  input  logic [NUM_AXES-1:0][CW-1:0]   in_hi_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [NUM_AXES-1:0][CW-1:0]   out_lo_o,
  output logic [NUM_AXES-1:0][CW-1:0]   out_hi_o
);

  localparam int PW = CW + COEF_W;           // one product
  localparam int SW = PW + 2;                // sum of three products
  localparam int TW = SW - COEF_FRAC;        // sum after the fraction shift
  localparam int AW = ((TW > SHIFT_W) ? TW : SHIFT_W) + 1;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic signed [COEF_W-1:0] coef     [NUM_AXES][NUM_AXES];
  logic signed [CW-1:0]     opn_min  [NUM_AXES][NUM_AXES];
  logic signed [CW-1:0]     opn_max  [NUM_AXES][NUM_AXES];
  logic signed [PW-1:0]     pmin_q   [NUM_AXES][NUM_AXES];
  logic signed [PW-1:0]     pmax_q   [NUM_AXES][NUM_AXES];
  logic signed [SW-1:0]     smin     [NUM_AXES];
  logic signed [SW-1:0]     smax     [NUM_AXES];
  logic signed [TW-1:0]     tmin_q   [NUM_AXES];
  logic signed [TW-1:0]     tmax_q   [NUM_AXES];
  logic signed [AW-1:0]     amin     [NUM_AXES];
  logic signed [AW-1:0]     amax     [NUM_AXES];
  logic [NUM_AXES-1:0][CW-1:0] lo_d, lo_q;
  logic [NUM_AXES-1:0][CW-1:0] hi_d, hi_q;

  // Each stage moves when it is empty or the stage after it moves.
  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Corners arrive ordered, so a negative coefficient takes its minimum at
  // the high corner and its maximum at the low one.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        coef[a][k] = $signed(cfg_i.row[a][k*COEF_W +: COEF_W]);
        if (coef[a][k][COEF_W-1]) begin
          opn_min[a][k] = $signed(in_hi_i[k]);
          opn_max[a][k] = $signed(in_lo_i[k]);
        end else begin
          opn_min[a][k] = $signed(in_lo_i[k]);
          opn_max[a][k] = $signed(in_hi_i[k]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int k = 0; k < NUM_AXES; k++) begin
          pmin_q[a][k] <= PW'(coef[a][k]) * PW'(opn_min[a][k]);
          pmax_q[a][k] <= PW'(coef[a][k]) * PW'(opn_max[a][k]);
        end
      end
    end
  end

  // Flooring the exact sum by the coefficient scale equals the sum of the
  // per-term floors plus the carried remainder.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      smin[a] = SW'(pmin_q[a][0]) + SW'(pmin_q[a][1]) + SW'(pmin_q[a][2]);
      smax[a] = SW'(pmax_q[a][0]) + SW'(pmax_q[a][1]) + SW'(pmax_q[a][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        tmin_q[a] <= smin[a][SW-1:COEF_FRAC];
        tmax_q[a] <= smax[a][SW-1:COEF_FRAC];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      amin[a] = AW'(tmin_q[a]) + AW'($signed(cfg_i.shift[a]));
      amax[a] = AW'(tmax_q[a]) + AW'($signed(cfg_i.shift[a]));
      if (amin[a][AW-1:CW-1] != {(AW-CW+1){amin[a][AW-1]}}) begin
        lo_d[a] = amin[a][AW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        lo_d[a] = amin[a][CW-1:0];
      end
      if (amax[a][AW-1:CW-1] != {(AW-CW+1){amax[a][AW-1]}}) begin
        hi_d[a] = amax[a][AW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        hi_d[a] = amax[a][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign out_valid_o = v3_q;
  assign out_lo_o    = lo_q;
  assign out_hi_o    = hi_q;

`ifndef SYNTHESIS
  a_back_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> ($signed(lo_q[0]) <= $signed(hi_q[0])) &&
             ($signed(lo_q[1]) <= $signed(hi_q[1])) &&
             ($signed(lo_q[2]) <= $signed(hi_q[2])))
    else $error("bound minimum exceeds maximum");
  a_back_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && rdy3) |=> v3_q)
    else $error("sum stage result was dropped");
`endif

endmodule
